FILE: rtl/core/next_fit_id_allocator_macros.svh
// assertion helpers shared by the allocator modules
// both expect a clk and an active-low arst_n in the using module
`ifndef NEXT_FIT_ID_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_ID_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NFID_ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NFID_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/nfid_pkg.sv
package nfid_pkg;

	// default table size
	localparam int unsigned NUM_SLOTS_DEF = 256;

	// occupancy bits examined per search cycle is 2**GRP_BITS
	localparam int unsigned GRP_BITS = 4;

	// field widths
	localparam int unsigned OP_W       = 2;
	localparam int unsigned DESC_W     = 64;
	localparam int unsigned SLOT_IN_W  = 8;
	localparam int unsigned SLOT_OUT_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_LOOKUP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EXEC,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic exec;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic found;
		logic exhausted;
	} stat_t;

endpackage

FILE: rtl/core/nfid_if.sv
// request channel
interface nfid_req_if;
	logic                              valid;
	logic                              ready;
	logic [nfid_pkg::OP_W-1:0]         operation;
	logic [nfid_pkg::DESC_W-1:0]       descriptor_in;
	logic [nfid_pkg::SLOT_IN_W-1:0]    slot_in;

	modport source (output valid, operation, descriptor_in, slot_in, input ready);
	modport sink   (input valid, operation, descriptor_in, slot_in, output ready);
endinterface

// response channel
interface nfid_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [nfid_pkg::SLOT_OUT_W-1:0]   slot_out;
	logic [nfid_pkg::DESC_W-1:0]       descriptor_out;
	logic                              none_free;

	modport source (output valid, slot_out, descriptor_out, none_free, input ready);
	modport sink   (input valid, slot_out, descriptor_out, none_free, output ready);
endinterface

FILE: rtl/core/next_fit_id_allocator.sv
// Next-fit identifier allocator over a table of NUM_SLOTS 64-bit descriptors.
// req channel: operation (allocate, release, look up), descriptor_in, slot_in.
// rsp channel: slot_out, descriptor_out, none_free; one transaction per request.
// Allocate searches the occupancy map circularly from the hint, 16 slots a
// cycle, stores the descriptor, and returns the slot (NUM_SLOTS if full).
// Release and lookup pass from the req transaction through the exec and
// finish states to rsp valid; allocate passes through the search state,
// one group per cycle (at least 2 search groups), then the finish state.
// One request is processed at a time; a new request is taken in the cycle
// after its predecessor's result is loaded into the output register.
// Reset clears the occupancy map and the hint; every slot reads as free and
// its descriptor as zero, so the descriptor store needs no clearing pass.
// When the receiver stalls, the result waits in the output register; the
// block still takes and processes one further request and then holds it
// until the output register frees.
module next_fit_id_allocator #(
	parameter int unsigned NUM_SLOTS = nfid_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nfid_req_if.sink    req,
	nfid_rsp_if.source  rsp
);

	nfid_pkg::cmd_t  cmd;
	nfid_pkg::stat_t stat;

	// sequencing
	nfid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.operation),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// table, search and result registers
	nfid_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.operation      (req.operation),
		.descriptor_in  (req.descriptor_in),
		.slot_in        (req.slot_in),
		.slot_out       (rsp.slot_out),
		.descriptor_out (rsp.descriptor_out),
		.none_free      (rsp.none_free)
	);

endmodule

FILE: rtl/core/nfid_ctrl.sv
`include "next_fit_id_allocator_macros.svh"

module nfid_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [nfid_pkg::OP_W-1:0]  in_op,
	output logic                       out_valid,
	input  logic                       out_ready,
	output nfid_pkg::cmd_t             cmd,
	input  nfid_pkg::stat_t            stat
);

	nfid_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			nfid_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = (in_op == nfid_pkg::OP_ALLOC) ? nfid_pkg::ST_SEARCH
					                                          : nfid_pkg::ST_EXEC;
				end
			end
			nfid_pkg::ST_SEARCH: begin
				cmd.step = 1'b1;
				if (stat.found || stat.exhausted) begin
					state_d = nfid_pkg::ST_FINISH;
				end
			end
			nfid_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = nfid_pkg::ST_FINISH;
			end
			nfid_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = nfid_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`NFID_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0({cmd.accept, cmd.step, cmd.exec, cmd.load_out}), "more than one datapath command at once")
	`NFID_ASSERT_SAME(a_load_free, cmd.load_out, !out_valid_q || out_ready, "result overwrites an untaken transaction")
	`NFID_ASSERT_NEXT(a_search_done, state_q == nfid_pkg::ST_SEARCH && stat.found, state_q == nfid_pkg::ST_FINISH, "search did not stop on a free slot")

endmodule

FILE: rtl/core/nfid_dp.sv
`include "next_fit_id_allocator_macros.svh"

module nfid_dp #(
	parameter int unsigned NUM_SLOTS = nfid_pkg::NUM_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nfid_pkg::cmd_t                    cmd,
	output nfid_pkg::stat_t                   stat,
	input  logic [nfid_pkg::OP_W-1:0]         operation,
	input  logic [nfid_pkg::DESC_W-1:0]       descriptor_in,
	input  logic [nfid_pkg::SLOT_IN_W-1:0]    slot_in,
	output logic [nfid_pkg::SLOT_OUT_W-1:0]   slot_out,
	output logic [nfid_pkg::DESC_W-1:0]       descriptor_out,
	output logic                              none_free
);

	localparam int unsigned IW     = $clog2(NUM_SLOTS);
	localparam int unsigned GB     = nfid_pkg::GRP_BITS;
	localparam int unsigned GW     = 1 << GB;
	localparam int unsigned NG_RAW = (NUM_SLOTS + GW - 1) / GW;
	localparam int unsigned NG     = (NG_RAW < 2) ? 2 : NG_RAW;
	localparam int unsigned GIW    = $clog2(NG);
	localparam int unsigned PW     = GIW + GB;
	localparam int unsigned NP     = NG * GW;
	localparam int unsigned KW     = $clog2(NG + 1);
	localparam int unsigned SOW    = nfid_pkg::SLOT_OUT_W;
	localparam int unsigned DW     = nfid_pkg::DESC_W;
	localparam logic [31:0] N32    = 32'(NUM_SLOTS);

	// captured request
	logic [nfid_pkg::OP_W-1:0]      op_q;
	logic [DW-1:0]                  desc_q;
	logic [nfid_pkg::SLOT_IN_W-1:0] slot_q;

	// occupancy map, next-fit hint and search position
	logic [NUM_SLOTS-1:0] occ_q;
	logic [IW-1:0]        hint_q;
	logic [GIW-1:0]       grp_q;
	logic [KW-1:0]        k_q;

	// results and read data
	logic [SOW-1:0] res_slot_q;
	logic           res_full_q;
	logic [DW-1:0]  rd_s1;
	logic           rd_ok_s1;
	logic [SOW-1:0] slot_out_q;
	logic [DW-1:0]  desc_out_q;
	logic           none_free_q;

	// descriptor store; a slot whose occupancy bit is clear reads as zero
	logic [DW-1:0] mem [NUM_SLOTS];

	logic [NP-1:0] occ_pad;
	logic [PW-1:0] hint_p;
	logic [GB-1:0] lo;
	logic [GW-1:0] grp_bits, mask_hi, mask, free;
	logic [GB-1:0] pos;
	logic [PW-1:0] found_p;
	logic [IW-1:0] fidx, next_hint, sidx;
	logic [31:0]   fidx32, slot32;
	logic          first, last, s_ok, commit, is_release;

	// padding beyond the table reads as occupied
	for (genvar j = 0; j < NP; j++) begin : g_pad
		if (j < NUM_SLOTS) begin : g_real
			assign occ_pad[j] = occ_q[j];
		end else begin : g_fill
			assign occ_pad[j] = 1'b1;
		end
	end

	// one group of the circular search per cycle
	assign hint_p   = PW'(hint_q);
	assign lo       = hint_p[GB-1:0];
	assign grp_bits = occ_pad[{grp_q, {GB{1'b0}}} +: GW];
	assign first    = (k_q == '0);
	assign last     = (k_q == KW'(NG));
	assign mask_hi  = {GW{1'b1}} << lo;
	assign mask     = first ? mask_hi : (last ? ~mask_hi : {GW{1'b1}});
	assign free     = ~grp_bits & mask;

	// lowest free bit in the group
	always_comb begin
		pos = '0;
		for (int j = GW - 1; j >= 0; j--) begin
			if (free[j]) begin
				pos = GB'(j);
			end
		end
	end

	assign found_p        = {grp_q, pos};
	assign fidx           = IW'(found_p);
	assign fidx32         = 32'(fidx);
	assign next_hint      = (fidx32 == N32 - 32'd1) ? '0 : fidx + IW'(1);
	assign stat.found     = |free;
	assign stat.exhausted = last & ~(|free);
	assign commit         = cmd.step & stat.found;

	// release and lookup addressing
	assign slot32     = 32'(slot_q);
	assign sidx       = slot32[IW-1:0];
	assign s_ok       = (slot32 < N32);
	assign is_release = (op_q == nfid_pkg::OP_RELEASE);

	// occupancy, hint and search counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			hint_q <= '0;
			grp_q  <= '0;
			k_q    <= '0;
		end else begin
			if (cmd.accept) begin
				grp_q <= hint_p[PW-1:GB];
				k_q   <= '0;
			end else if (cmd.step) begin
				grp_q <= (grp_q == GIW'(NG - 1)) ? '0 : grp_q + GIW'(1);
				k_q   <= k_q + KW'(1);
			end
			if (commit) begin
				occ_q[fidx] <= (desc_q != '0);
				hint_q      <= next_hint;
			end else if (cmd.exec && is_release && s_ok) begin
				occ_q[sidx] <= 1'b0;
			end
		end
	end

	// descriptor store port
	always_ff @(posedge clk) begin
		if (commit) begin
			mem[fidx] <= desc_q;
		end
		if (cmd.exec) begin
			rd_s1 <= mem[sidx];
		end
	end

	// request capture, results and output register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			desc_q <= descriptor_in;
			slot_q <= slot_in;
		end
		if (cmd.step) begin
			if (stat.found) begin
				res_slot_q <= fidx32[SOW-1:0];
				res_full_q <= 1'b0;
			end else begin
				res_slot_q <= N32[SOW-1:0];
				res_full_q <= 1'b1;
			end
		end
		if (cmd.exec) begin
			rd_ok_s1 <= s_ok & occ_q[sidx];
		end
		if (cmd.load_out) begin
			unique case (nfid_pkg::op_t'(op_q))
				nfid_pkg::OP_ALLOC: begin
					slot_out_q  <= res_slot_q;
					desc_out_q  <= '0;
					none_free_q <= res_full_q;
				end
				nfid_pkg::OP_LOOKUP: begin
					slot_out_q  <= '0;
					desc_out_q  <= rd_ok_s1 ? rd_s1 : '0;
					none_free_q <= 1'b0;
				end
				default: begin
					slot_out_q  <= '0;
					desc_out_q  <= '0;
					none_free_q <= 1'b0;
				end
			endcase
		end
	end

	assign slot_out       = slot_out_q;
	assign descriptor_out = desc_out_q;
	assign none_free      = none_free_q;

	// checks
	`NFID_ASSERT_SAME(a_hint_range, 1'b1, 32'(hint_q) < N32, "search hint beyond table")
	`NFID_ASSERT_SAME(a_found_range, cmd.step && stat.found, fidx32 < N32, "search found a padding slot")
	`NFID_ASSERT_NEXT(a_commit_occ, commit && (desc_q != '0), occ_q[$past(fidx)], "allocated slot not marked occupied")

endmodule
